// ===== hw/rtl/oaht_pkg.sv =====
// Shared types and codes for the open-addressing hash table.
`timescale 1ns / 1ps

package oaht_pkg;

  // request modes
  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // response status codes
  localparam logic [2:0] STAT_NEW      = 3'd0;
  localparam logic [2:0] STAT_UPDATED  = 3'd1;
  localparam logic [2:0] STAT_FOUND    = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_REMOVED  = 3'd4;
  localparam logic [2:0] STAT_FULL     = 3'd5;

  // slot tags
  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_USED  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] value_in;
  } oaht_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value_out;
  } oaht_rsp_t;

endpackage

// ===== hw/rtl/open_addressing_hash_table_core.sv =====
// Open-addressing hash table core: linear probing with tombstones over slot memories.
`timescale 1ns / 1ps

// Fixed-capacity key/value table. A request (set, get, remove) is taken only while the
// sequencer is idle; the probe then reads one slot per cycle from the tag, key and value
// memories through a single read port each, stopping on a key match, on an empty slot or
// after CAPACITY slots. When CAPACITY is not a power of two the hash is first reduced by a
// reciprocal multiply on one shared multiplier; a request that needs no probe (set at the
// load limit, get or remove on an empty table, unused mode) goes straight to completion.
// A stalled result holds the sequencer in its final state. Sets are refused with status
// full once used slots (tombstones included) reach three quarters of capacity. After reset
// the tag memory is swept to empty, one slot per cycle, and no request is taken during the
// sweep. The result sits in an output register, so a new request may be taken while the
// previous result is still waiting.
module open_addressing_hash_table_core
  import oaht_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  oaht_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output oaht_rsp_t out_rsp_o
);

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LIMIT    = (3 * CAPACITY + 3) / 4;
  localparam int UC_W     = $clog2(LIMIT + 1);
  localparam bit IS_POW2  = ((1 << IDX_W) == CAPACITY);
  localparam int RECIP_SH = 32 + IDX_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [UC_W-1:0]  LIMIT_UC = UC_W'(LIMIT);
  // ceil(2^(32+IDX_W) / CAPACITY): exact quotient for every 32-bit hash
  localparam logic [32:0]      RECIP    =
    33'(((64'd1 << RECIP_SH) + 64'(CAPACITY - 1)) / 64'(CAPACITY));
  localparam logic [32:0]      CAP_MUL  = 33'(CAPACITY);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  oaht_req_t req_q, req_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [1:0]       mph_q, mph_d;
  logic [64:0]      acc_q, acc_d;
  logic [IDX_W-1:0] tomb_idx_q, tomb_idx_d;
  logic             tomb_vld_q, tomb_vld_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             hit_q, hit_d;
  logic             ok_q, ok_d;
  logic             grow_q, grow_d;
  logic [63:0]      fval_q, fval_d;
  logic [UC_W-1:0]  used_q, used_d;
  logic             out_valid_q, out_valid_d;
  oaht_rsp_t        out_q, out_d;

  // slot memories
  logic [1:0]  tag_mem [CAPACITY];
  logic [31:0] key_mem [CAPACITY];
  logic [63:0] val_mem [CAPACITY];
  logic [1:0]  rd_tag_q;
  logic [31:0] rd_key_q;
  logic [63:0] rd_val_q;

  logic [IDX_W-1:0] rd_addr;
  logic             tag_we;
  logic [IDX_W-1:0] tag_wa;
  logic [1:0]       tag_wd;
  logic             kv_we;

  logic             accept;
  logic             full;
  logic             out_free;
  logic [IDX_W-1:0] idx_nxt;
  logic [31:0]      mul_a;
  logic [32:0]      mul_b;
  logic [64:0]      mul_p;
  logic [31:0]      quot;
  logic [31:0]      rem;
  logic             is_tomb;
  logic             tomb_have;
  logic [IDX_W-1:0] tomb_now;
  logic [2:0]       status;

  assign accept   = in_valid_i && !in_stall_o;
  assign full     = (used_q >= LIMIT_UC);
  assign out_free = !out_valid_q || !out_stall_i;
  assign idx_nxt  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

  // shared multiplier for the hash reduction
  assign mul_p = {33'd0, mul_a} * {32'd0, mul_b};
  assign quot  = 32'(acc_q >> RECIP_SH);
  assign rem   = req_q.key_hash - mul_p[31:0];

  assign is_tomb   = (rd_tag_q != TAG_EMPTY) && (rd_tag_q != TAG_USED);
  assign tomb_have = tomb_vld_q || is_tomb;
  assign tomb_now  = tomb_vld_q ? tomb_idx_q : idx_q;

  always_comb begin
    status = STAT_NOTFOUND;
    case (req_q.mode)
      MODE_SET: begin
        if (!ok_q) begin
          status = STAT_FULL;
        end else if (hit_q) begin
          status = STAT_UPDATED;
        end else begin
          status = STAT_NEW;
        end
      end
      MODE_GET:    status = hit_q ? STAT_FOUND : STAT_NOTFOUND;
      MODE_REMOVE: status = hit_q ? STAT_REMOVED : STAT_NOTFOUND;
      default:     status = STAT_NOTFOUND;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    step_d      = step_q;
    clr_d       = clr_q;
    mph_d       = mph_q;
    acc_d       = acc_q;
    tomb_idx_d  = tomb_idx_q;
    tomb_vld_d  = tomb_vld_q;
    slot_d      = slot_q;
    hit_d       = hit_q;
    ok_d        = ok_q;
    grow_d      = grow_q;
    fval_d      = fval_q;
    used_d      = used_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_addr     = idx_q;
    tag_we      = 1'b0;
    tag_wa      = slot_q;
    tag_wd      = TAG_USED;
    kv_we       = 1'b0;
    mul_a       = '0;
    mul_b       = RECIP;

    unique case (state_q)
      ST_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = clr_q;
        tag_wd = TAG_EMPTY;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_d      = in_req_i;
          hit_d      = 1'b0;
          ok_d       = 1'b0;
          grow_d     = 1'b0;
          tomb_vld_d = 1'b0;
          step_d     = '0;
          mph_d      = '0;
          if ((in_req_i.mode == MODE_SET) ? full :
              ((in_req_i.mode != MODE_GET && in_req_i.mode != MODE_REMOVE) ||
               used_q == '0)) begin
            state_d = ST_DONE;
          end else if (IS_POW2) begin
            idx_d   = in_req_i.key_hash[IDX_W-1:0];
            state_d = ST_READ;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        // two partial products of hash * reciprocal, then hash - quotient * CAPACITY
        mph_d = mph_q + 1'b1;
        if (mph_q == 2'd0) begin
          mul_a = {16'd0, req_q.key_hash[15:0]};
          acc_d = mul_p;
        end else if (mph_q == 2'd1) begin
          mul_a = {16'd0, req_q.key_hash[31:16]};
          acc_d = acc_q + {mul_p[48:0], 16'd0};
        end else begin
          mul_a   = quot;
          mul_b   = CAP_MUL;
          idx_d   = rem[IDX_W-1:0];
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // read the following slot speculatively while this one is examined
        rd_addr = idx_nxt;
        if (rd_tag_q == TAG_EMPTY) begin
          slot_d  = tomb_now;
          ok_d    = 1'b1;
          grow_d  = !tomb_vld_q;
          state_d = ST_DONE;
        end else if (rd_tag_q == TAG_USED && rd_key_q == req_q.key_id) begin
          slot_d  = idx_q;
          hit_d   = 1'b1;
          ok_d    = 1'b1;
          fval_d  = rd_val_q;
          state_d = ST_DONE;
        end else if (step_q == LAST_IDX) begin
          // probe exhausted: only a tombstone can take the key
          slot_d  = tomb_now;
          ok_d    = tomb_have;
          state_d = ST_DONE;
        end else begin
          if (is_tomb && !tomb_vld_q) begin
            tomb_vld_d = 1'b1;
            tomb_idx_d = idx_q;
          end
          idx_d  = idx_nxt;
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = status;
          out_d.value_out = (status == STAT_FOUND) ? fval_q : 64'd0;
          if (req_q.mode == MODE_SET && ok_q) begin
            tag_we = 1'b1;
            tag_wd = TAG_USED;
            kv_we  = 1'b1;
            if (grow_q) begin
              used_d = used_q + 1'b1;
            end
          end else if (req_q.mode == MODE_REMOVE && hit_q) begin
            tag_we = 1'b1;
            tag_wd = TAG_TOMB;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      tomb_vld_q  <= 1'b0;
      hit_q       <= 1'b0;
      ok_q        <= 1'b0;
      grow_q      <= 1'b0;
      step_q      <= '0;
      mph_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      tomb_vld_q  <= tomb_vld_d;
      hit_q       <= hit_d;
      ok_q        <= ok_d;
      grow_q      <= grow_d;
      step_q      <= step_d;
      mph_q       <= mph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    idx_q      <= idx_d;
    acc_q      <= acc_d;
    tomb_idx_q <= tomb_idx_d;
    slot_q     <= slot_d;
    fval_q     <= fval_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    rd_tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      key_mem[slot_q] <= req_q.key_id;
    end
    rd_key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      val_mem[slot_q] <= req_q.value_in;
    end
    rd_val_q <= val_mem[rd_addr];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // occupancy never passes the load limit
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= LIMIT_UC)
    else $error("used count above load limit");

  // occupancy grows by one only when a transaction completes
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      ($past(state_q) == ST_DONE && used_q == $past(used_q) + 1'b1))
    else $error("used count changed outside completion");

  // a new result only appears from the completion state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside completion");

  // a value is only returned with status found
  a_val_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.value_out != 64'd0) |-> out_rsp_o.status == STAT_FOUND)
    else $error("value returned without found status");

  // no tag write while a probe is walking the table
  a_no_wr_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_CHECK || state_q == ST_MOD) |-> !tag_we && !kv_we)
    else $error("slot write during probe");

endmodule
